[sv/ffsa_pkg.sv]
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types, codes and defaults of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int DEF_MAX_SEGMENTS = 16;
  localparam int DEF_ADDR_WIDTH   = 16;

  localparam logic [15:0] TOTAL_RESET = 16'hFFFF;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOFIT    = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHU,
    ST_INS,
    ST_MERGE,
    ST_SHD,
    ST_DONE
  } state_t;

endpackage

[sv/first_fit_segment_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit allocator over an ordered segment table with coalescing on free.
// ----------------------------------------------------------------------------
// The segment table lives in one memory with a registered read port, one entry
// per row, and is walked one entry per cycle. An allocate scans from entry 0
// to the first free segment that fits; a split then moves the entries behind
// it up by one, one per cycle, and adds the remainder. A free scans to its
// segment and, when it merges, moves the entries behind the merged ones down,
// again one per cycle. An item's time is therefore bounded by the single
// table memory port. Result beats go through an output register, so a waiting
// result only stalls the block once the next result is ready. Reset and a
// total_size write take effect at once with no clearing pass: entry 0 reads
// as one free segment covering the whole range until it is first written.
// total_size is accepted only while idle.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator #(
  parameter int MAX_SEGMENTS = ffsa_pkg::DEF_MAX_SEGMENTS,
  parameter int ADDR_WIDTH   = ffsa_pkg::DEF_ADDR_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] total_size,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [15:0] request_size,
  input  logic [15:0] free_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] address,
  output logic [1:0]  status
);
  import ffsa_pkg::*;

  localparam int AW = ADDR_WIDTH;
  localparam int CW = (ADDR_WIDTH > 16) ? ADDR_WIDTH : 16;
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int NW = $clog2(MAX_SEGMENTS + 1);

  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] size;
    logic          free;
  } seg_t;

  seg_t          mem [MAX_SEGMENTS];
  seg_t          mem_q;

  state_t        state;
  state_t        state_next;
  logic [NW-1:0] seg_count;
  logic [AW-1:0] total_reg;
  logic          fresh;
  logic          rd_fresh;
  logic          rd_vld;
  logic [IW-1:0] rd_idx;
  logic [NW-1:0] ptr;
  logic [IW-1:0] hit_idx;
  seg_t          hit;
  seg_t          prev;
  logic          gap2;
  logic          op;
  logic [15:0]   req;
  logic [15:0]   fad;
  logic [15:0]   res_addr;
  logic [1:0]    res_status;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  seg_t          wr_data;

  seg_t          init_ent;
  seg_t          rd_ent;
  logic          fit;
  logic          own;
  logic          exact;
  logic          full;
  logic          scan_hit;
  logic          scan_miss;
  logic          alloc_write;
  logic          scan_issue;
  logic          up_issue;
  logic          dn_issue;
  logic          pf;
  logic          nf;
  logic [AW-1:0] sum_pe;
  logic [AW-1:0] sum_en;
  logic [AW-1:0] sum_all;
  logic          out_free;
  logic          in_fire;
  logic          cfg_fire;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_comb begin
    init_ent    = '{start: '0, size: total_reg, free: 1'b1};
    rd_ent      = rd_fresh ? init_ent : mem_q;
    fit         = rd_ent.free && (CW'(rd_ent.size) >= CW'(req));
    own         = !rd_ent.free && (CW'(rd_ent.start) == CW'(fad));
    exact       = CW'(rd_ent.size) == CW'(req);
    full        = seg_count == NW'(MAX_SEGMENTS);
    scan_hit    = (state == ST_SCAN) && rd_vld && ((op == CMD_ALLOC) ? fit : own);
    scan_miss   = (state == ST_SCAN) && rd_vld && !scan_hit
                  && (NW'(rd_idx) == seg_count - NW'(1));
    alloc_write = scan_hit && (op == CMD_ALLOC) && !(full && !exact);
    scan_issue  = (state == ST_SCAN) && (ptr < seg_count)
                  && !(scan_hit && (op == CMD_ALLOC));
    up_issue    = (state == ST_SHU) && (ptr > NW'(hit_idx));
    dn_issue    = (state == ST_SHD) && (ptr < seg_count);
    pf          = (hit_idx != '0) && prev.free;
    nf          = rd_vld && rd_ent.free;
    sum_pe      = prev.size + hit.size;
    sum_en      = hit.size + rd_ent.size;
    sum_all     = sum_pe + rd_ent.size;
    out_free    = !out_valid || out_ready;
    in_fire     = in_valid && in_ready;
    cfg_fire    = cfg_valid && cfg_ready;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (cmd == CMD_ALLOC && request_size == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          if (op == CMD_FREE) begin
            state_next = ST_MERGE;
          end else if (exact || full) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SHU;
          end
        end else if (scan_miss) begin
          state_next = ST_DONE;
        end
      end
      ST_SHU: begin
        if (!up_issue && !rd_vld) begin
          state_next = ST_INS;
        end
      end
      ST_INS: begin
        state_next = ST_DONE;
      end
      ST_MERGE: begin
        state_next = (pf || nf) ? ST_SHD : ST_DONE;
      end
      ST_SHD: begin
        if (!dn_issue && !rd_vld) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE) && !cfg_valid;
    cfg_ready = state == ST_IDLE;
    rd_en     = scan_issue || up_issue || dn_issue;
    rd_addr   = ptr[IW-1:0];
    wr_en     = 1'b0;
    wr_addr   = rd_idx;
    wr_data   = rd_ent;
    case (state)
      ST_SCAN: begin
        if (alloc_write) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx;
          wr_data = '{start: rd_ent.start, size: AW'(req), free: 1'b0};
        end
      end
      ST_SHU: begin
        if (rd_vld) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx + IW'(1);
          wr_data = rd_ent;
        end
      end
      ST_INS: begin
        wr_en   = 1'b1;
        wr_addr = hit_idx + IW'(1);
        wr_data = '{start: hit.start + AW'(req), size: hit.size - AW'(req), free: 1'b1};
      end
      ST_MERGE: begin
        wr_en = 1'b1;
        if (pf) begin
          wr_addr = hit_idx - IW'(1);
          wr_data = '{start: prev.start, size: nf ? sum_all : sum_pe, free: 1'b1};
        end else begin
          wr_addr = hit_idx;
          wr_data = '{start: hit.start, size: nf ? sum_en : hit.size, free: 1'b1};
        end
      end
      ST_SHD: begin
        if (rd_vld) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx - (gap2 ? IW'(2) : IW'(1));
          wr_data = rd_ent;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seg_count <= NW'(1);
      total_reg <= AW'(TOTAL_RESET);
      fresh     <= 1'b1;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= rd_en;
      if (cfg_fire) begin
        total_reg <= AW'(total_size);
        seg_count <= NW'(1);
        fresh     <= 1'b1;
      end else begin
        if (wr_en && wr_addr == '0) begin
          fresh <= 1'b0;
        end
        if (state == ST_INS) begin
          seg_count <= seg_count + NW'(1);
        end else if (state == ST_SHD && !dn_issue && !rd_vld) begin
          seg_count <= seg_count - (gap2 ? NW'(2) : NW'(1));
        end
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx   <= rd_addr;
      rd_fresh <= fresh && (rd_addr == '0);
    end
    if (in_fire) begin
      op       <= cmd;
      req      <= request_size;
      fad      <= free_address;
      ptr      <= '0;
      res_addr <= '0;
      if (cmd == CMD_ALLOC && request_size == '0) begin
        res_status <= STATUS_NOFIT;
      end else begin
        res_status <= STATUS_OK;
      end
    end
    case (state)
      ST_SCAN: begin
        if (rd_en) begin
          ptr <= ptr + NW'(1);
        end
        if (rd_vld && !scan_hit) begin
          prev <= rd_ent;
        end
        if (scan_hit) begin
          hit     <= rd_ent;
          hit_idx <= rd_idx;
          if (op == CMD_ALLOC) begin
            ptr <= seg_count - NW'(1);
            if (full && !exact) begin
              res_status <= STATUS_FULL;
            end else begin
              res_addr <= 16'(rd_ent.start);
            end
          end
        end
        if (scan_miss) begin
          res_status <= (op == CMD_ALLOC) ? STATUS_NOFIT : STATUS_NOTFOUND;
        end
      end
      ST_SHU: begin
        if (rd_en) begin
          ptr <= ptr - NW'(1);
        end
      end
      ST_MERGE: begin
        ptr  <= NW'(hit_idx) + (nf ? NW'(2) : NW'(1));
        gap2 <= pf && nf;
      end
      ST_SHD: begin
        if (rd_en) begin
          ptr <= ptr + NW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          address <= res_addr;
          status  <= res_status;
        end
      end
      default: begin
        gap2 <= gap2;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    seg_count != '0 && seg_count <= NW'(MAX_SEGMENTS))
    else $error("segment count out of range");

  a_cfg_reinit: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> seg_count == NW'(1) && fresh)
    else $error("table not reinitialized after total_size write");

  a_shift_up_room: assert property (@(posedge clk) disable iff (rst)
    state == ST_SHU |-> seg_count < NW'(MAX_SEGMENTS))
    else $error("split started on a full table");

  a_write_in_table: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> NW'(wr_addr) <= seg_count)
    else $error("table write beyond the valid entries");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result beat raised outside completion");
`endif

endmodule

[verif/ffsa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_checker
// Watches the configuration, command and reply channels of the first-fit
// segment allocator. It keeps its own copy of the segment map, works out the
// address and status of every accepted command, and compares each reply beat
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ffsa_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] total_size,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        cmd,
  input  logic [15:0] request_size,
  input  logic [15:0] free_address,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] address,
  input  logic [1:0]  status,
  output int          fail_count,
  output int          pending,
  output int          n_ok,
  output int          n_nofit,
  output int          n_full,
  output int          n_notfound,
  output int          n_resizes
);
  import ffsa_pkg::*;

  localparam int SEGS = DEF_MAX_SEGMENTS;

  typedef struct packed {
    logic [15:0] address;
    logic [1:0]  status;
  } reply_t;

  logic [15:0] seg_base [SEGS];
  logic [15:0] seg_len  [SEGS];
  logic        seg_open [SEGS];
  int          seg_used;
  reply_t      replies_due [$];
  reply_t      got;
  reply_t      want;

  function automatic void rebuild_map(input logic [15:0] span);
    int k;
    for (k = 0; k < SEGS; k++) begin
      seg_base[k] = '0;
      seg_len[k]  = '0;
      seg_open[k] = 1'b0;
    end
    seg_len[0]  = span;
    seg_open[0] = 1'b1;
    seg_used    = 1;
  endfunction

  function automatic void close_gap(input int k);
    int j;
    for (j = k; j + 1 < seg_used; j++) begin
      seg_base[j] = seg_base[j + 1];
      seg_len[j]  = seg_len[j + 1];
      seg_open[j] = seg_open[j + 1];
    end
    seg_used--;
    seg_base[seg_used] = '0;
    seg_len[seg_used]  = '0;
    seg_open[seg_used] = 1'b0;
  endfunction

  function automatic reply_t take_first_fit(input logic [15:0] req);
    int          i;
    int          j;
    int          hit;
    logic [15:0] rest;
    reply_t      r;
    r.address = '0;
    r.status  = STATUS_NOFIT;
    hit = -1;
    if (req == '0) return r;
    for (i = 0; i < seg_used; i++)
      if (hit < 0 && seg_open[i] && seg_len[i] >= req) hit = i;
    if (hit < 0) return r;
    rest = seg_len[hit] - req;
    if (rest != '0) begin
      if (seg_used >= SEGS) begin
        r.status = STATUS_FULL;
        return r;
      end
      for (j = seg_used; j > hit + 1; j--) begin
        seg_base[j] = seg_base[j - 1];
        seg_len[j]  = seg_len[j - 1];
        seg_open[j] = seg_open[j - 1];
      end
      seg_base[hit + 1] = seg_base[hit] + req;
      seg_len[hit + 1]  = rest;
      seg_open[hit + 1] = 1'b1;
      seg_used++;
    end
    seg_len[hit]  = req;
    seg_open[hit] = 1'b0;
    r.address = seg_base[hit];
    r.status  = STATUS_OK;
    return r;
  endfunction

  function automatic reply_t release_at(input logic [15:0] base);
    int     i;
    int     hit;
    reply_t r;
    r.address = '0;
    r.status  = STATUS_NOTFOUND;
    hit = -1;
    for (i = 0; i < seg_used; i++)
      if (hit < 0 && !seg_open[i] && seg_base[i] == base) hit = i;
    if (hit < 0) return r;
    seg_open[hit] = 1'b1;
    // merge backward first, then forward from the merged position
    if (hit > 0 && seg_open[hit - 1]) begin
      seg_len[hit - 1] = seg_len[hit - 1] + seg_len[hit];
      close_gap(hit);
      hit--;
    end
    if (hit + 1 < seg_used && seg_open[hit + 1]) begin
      seg_len[hit] = seg_len[hit] + seg_len[hit + 1];
      close_gap(hit + 1);
    end
    r.status = STATUS_OK;
    return r;
  endfunction

  function automatic void log_miss(input string why, input reply_t w, input reply_t g);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] %s: expected address %h status %0d, got address %h status %0d",
               $time, why, w.address, w.status, g.address, g.status);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rebuild_map(TOTAL_RESET);
      replies_due.delete();
      fail_count = 0;
      n_ok       = 0;
      n_nofit    = 0;
      n_full     = 0;
      n_notfound = 0;
      n_resizes  = 1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rebuild_map(total_size);
        n_resizes++;
      end
      if (out_valid && out_ready) begin
        got.address = address;
        got.status  = status;
        if (replies_due.size() == 0) begin
          log_miss("reply with nothing outstanding", '0, got);
        end else begin
          want = replies_due.pop_front();
          if (got.address !== want.address || got.status !== want.status)
            log_miss("reply mismatch", want, got);
          case (want.status)
            STATUS_OK:    n_ok++;
            STATUS_NOFIT: n_nofit++;
            STATUS_FULL:  n_full++;
            default:      n_notfound++;
          endcase
        end
      end
      if (in_valid && in_ready) begin
        if (cmd == CMD_FREE)
          replies_due.push_back(release_at(free_address));
        else
          replies_due.push_back(take_first_fit(request_size));
      end
    end
    pending = replies_due.size();
  end

endmodule

[verif/tb_first_fit_segment_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_segment_allocator
// Drives allocate and free commands into the segment allocator under several
// memory sizes, with bursty command beats and a stalling reply side. Most
// frees release segments that were actually granted; the rest name random
// starts. Prediction and comparison live in ffsa_checker.
// ----------------------------------------------------------------------------
module tb_first_fit_segment_allocator;
  import ffsa_pkg::*;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [15:0] total_size   = TOTAL_RESET;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic        cmd          = CMD_ALLOC;
  logic [15:0] request_size = '0;
  logic [15:0] free_address = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [15:0] address;
  logic [1:0]  status;

  int fail_count;
  int pending;
  int n_ok;
  int n_nofit;
  int n_full;
  int n_notfound;
  int n_resizes;

  int          burst_left = 0;
  int          cur_total  = 65535;
  int          n_sent     = 0;
  int          rx_mode    = 0;
  int          rx_left    = 0;
  int          rx_tick    = 0;
  logic [15:0] live_q [$];
  logic        sent_cmds [$];
  logic        was_alloc;

  first_fit_segment_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .total_size   (total_size),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .request_size (request_size),
    .free_address (free_address),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .address      (address),
    .status       (status)
  );

  ffsa_checker reply_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .total_size   (total_size),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .request_size (request_size),
    .free_address (free_address),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .address      (address),
    .status       (status),
    .fail_count   (fail_count),
    .pending      (pending),
    .n_ok         (n_ok),
    .n_nofit      (n_nofit),
    .n_full       (n_full),
    .n_notfound   (n_notfound),
    .n_resizes    (n_resizes)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 1) == 0);
      2:       out_ready <= ($urandom_range(0, 5) == 0);
      default: out_ready <= ((rx_tick % 5) < 3);
    endcase
  end

  // track granted starts so that most frees name a live segment
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready && sent_cmds.size() != 0) begin
      was_alloc = (sent_cmds.pop_front() == CMD_ALLOC);
      if (was_alloc && status == STATUS_OK) live_q.push_back(address);
    end
  end

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if ($urandom_range(0, 5) == 0)
        burst_left = $urandom_range(60, 150);
      else
        burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic send_beat(input logic c, input logic [15:0] rs, input logic [15:0] fa);
    pace();
    in_valid     <= 1'b1;
    cmd          <= c;
    request_size <= rs;
    free_address <= fa;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cmds.push_back(c);
    n_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_total(input logic [15:0] span);
    cfg_valid  <= 1'b1;
    total_size <= span;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    live_q.delete();
    cur_total = int'(span);
  endtask

  task automatic random_run(input int n);
    int          k;
    int          sel;
    int          cap;
    int          idx;
    logic [15:0] rs;
    logic [15:0] fa;
    cap = (cur_total == 0) ? 1 : cur_total;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        sel = $urandom_range(0, 99);
        if (sel < 60)
          rs = 16'($urandom_range(1, (cap / 12 < 1) ? 1 : cap / 12));
        else if (sel < 75)
          rs = 16'($urandom_range(1, cap));
        else if (sel < 85)
          case ($urandom_range(0, 2))
            0:       rs = '0;
            1:       rs = 16'(cur_total);
            default: rs = 16'hFFFF;
          endcase
        else
          rs = 16'($urandom);
        send_beat(CMD_ALLOC, rs, 16'($urandom));
      end else begin
        if (live_q.size() != 0 && sel < 90) begin
          idx = $urandom_range(0, live_q.size() - 1);
          fa  = live_q[idx];
          live_q.delete(idx);
        end else if ($urandom_range(0, 1) == 0) begin
          fa = 16'($urandom);
        end else begin
          fa = 16'($urandom_range(0, cap));
        end
        send_beat(CMD_FREE, 16'($urandom), fa);
      end
    end
    settle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // whole memory after reset: zero size, no fit, unknown starts, both merges
    send_beat(CMD_ALLOC, 16'd0, 16'($urandom));
    send_beat(CMD_ALLOC, 16'd1, 16'($urandom));
    send_beat(CMD_ALLOC, 16'hFFFF, 16'($urandom));
    send_beat(CMD_FREE, 16'($urandom), 16'd0);
    send_beat(CMD_FREE, 16'($urandom), 16'd0);
    send_beat(CMD_FREE, 16'($urandom), 16'hFFFF);
    send_beat(CMD_ALLOC, 16'hFFFF, 16'($urandom));
    send_beat(CMD_FREE, 16'($urandom), 16'd0);
    send_beat(CMD_ALLOC, 16'd10, 16'($urandom));
    send_beat(CMD_ALLOC, 16'd10, 16'($urandom));
    send_beat(CMD_ALLOC, 16'd10, 16'($urandom));
    send_beat(CMD_FREE, 16'($urandom), 16'd0);
    send_beat(CMD_FREE, 16'($urandom), 16'd20);
    send_beat(CMD_FREE, 16'($urandom), 16'd10);
    settle();

    // fill the map: split refused when full, exact fit still granted
    write_total(16'd17);
    repeat (15) send_beat(CMD_ALLOC, 16'd1, 16'($urandom));
    send_beat(CMD_ALLOC, 16'd1, 16'($urandom));
    send_beat(CMD_ALLOC, 16'd2, 16'($urandom));
    settle();

    write_total(16'hFFFF);
    random_run(250);
    write_total(16'd1);
    random_run(60);
    write_total(16'd0);
    random_run(40);
    write_total(16'd17);
    random_run(200);
    write_total(16'($urandom_range(40, 400)));
    random_run(250);
    write_total(16'($urandom_range(1000, 65534)));
    random_run(250);
    write_total(16'hFFFF);
    random_run(250);

    $display("Sent %0d allocate/free commands across %0d memory sizes.", n_sent, n_resizes);
    $display("Replies: %0d ok, %0d no fit, %0d table full, %0d start not found.",
             n_ok, n_nofit, n_full, n_notfound);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Timeout with %0d replies outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[first_fit_segment_allocator.f]
sv/ffsa_pkg.sv
sv/first_fit_segment_allocator.sv
verif/ffsa_checker.sv
verif/tb_first_fit_segment_allocator.sv
